FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // field widths of the item channels
    localparam int KIND_W            = 3;
    localparam int FIELD_W           = 32;
    localparam int RES_W             = 64;
    localparam int OPERAND_WIDTH_DEF = 32;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MUL  = 3'd2,
        KIND_DIV  = 3'd3,
        KIND_SIMP = 3'd4
    } t_kind;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_GCD,
        ST_GCD_WAIT,
        ST_QA_WAIT,
        ST_QB,
        ST_QB_WAIT,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channels of the rational arithmetic unit: operand items in,
// result items out.
// ----------------------------------------------------------------------------
interface rau_in_if import rau_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] first_num;
    logic signed [FIELD_W-1:0] first_den;
    logic signed [FIELD_W-1:0] second_num;
    logic signed [FIELD_W-1:0] second_den;

    modport source (
        output valid, kind, first_num, first_den, second_num, second_den,
        input  ready
    );
    modport sink (
        input  valid, kind, first_num, first_den, second_num, second_den,
        output ready
    );
endinterface

interface rau_out_if import rau_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_num;
    logic signed [RES_W-1:0] result_den;
    logic                    zero_divisor;
    logic                    overflowed;

    modport source (
        output valid, result_num, result_den, zero_divisor, overflowed,
        input  ready
    );
    modport sink (
        input  valid, result_num, result_den, zero_divisor, overflowed,
        output ready
    );
endinterface

FILE: rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Unsigned restoring divider, one quotient bit per cycle. Gives quotient
// and remainder in the cycle after the last step, flagged by o_done.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; #(
    parameter int W = OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    // one restoring step
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide or simplify fractions, one item at a time.
// ----------------------------------------------------------------------------
// One item is taken at a time; the input is ready only while the sequencer
// is idle, and a finished result waits in the output register so the next
// item can be taken meanwhile. Add or subtract with equal denominators skips
// the products; multiply, divide and cross-multiplied add or subtract run
// on a single shared OPERAND_WIDTH multiplier used once per product.
// Simplify runs the Euclid remainder loop and then two quotients on one
// restoring divider of OPERAND_WIDTH steps. Results are not reduced except
// by simplify; a cross-multiplied sum or difference that overflows wraps to
// 64 bits and raises overflowed.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rau_in_if.sink   i_in,
    rau_out_if.source o_out
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;

    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [1:0]             r_step, n_step;
    logic signed [W-1:0]    r_a, r_b, r_c, r_d;
    logic signed [W-1:0]    n_a, n_b, n_c, n_d;
    logic signed [PW-1:0]   r_prod;
    logic signed [RES_W-1:0] r_num, n_num;
    logic signed [RES_W-1:0] r_den, n_den;
    logic                   r_zd, n_zd;
    logic                   r_ov, n_ov;
    logic signed [W:0]      r_p, n_p;
    logic signed [W:0]      r_q, n_q;
    logic                   r_out_valid, n_out_valid;
    logic signed [RES_W-1:0] r_out_num, n_out_num;
    logic signed [RES_W-1:0] r_out_den, n_out_den;
    logic                   r_out_zd, n_out_zd;
    logic                   r_out_ov, n_out_ov;

    logic signed [W-1:0]    w_mx, w_my;
    logic signed [RES_W-1:0] w_prod64;
    logic signed [RES_W-1:0] w_sum;
    logic signed [W:0]      w_a_ext, w_b_ext, w_a_neg, w_b_neg, w_p_neg, w_q_neg;
    logic [W-1:0]           w_a_mag, w_b_mag, w_p_mag, w_q_mag;
    logic signed [W:0]      w_rem_ext;
    logic [RES_W-1:0]       w_quo64;
    logic signed [RES_W-1:0] w_quo_pos, w_quo_neg;
    logic                   w_div_start;
    logic [W-1:0]           w_div_dvd, w_div_dvs;
    logic                   w_div_done;
    logic [W-1:0]           w_div_quo, w_div_rem;

    // shared divider
    rau_div #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // magnitudes for the divider
    assign w_a_ext  = (W+1)'(r_a);
    assign w_b_ext  = (W+1)'(r_b);
    assign w_a_neg  = -w_a_ext;
    assign w_b_neg  = -w_b_ext;
    assign w_p_neg  = -r_p;
    assign w_q_neg  = -r_q;
    assign w_a_mag  = r_a[W-1] ? w_a_neg[W-1:0] : w_a_ext[W-1:0];
    assign w_b_mag  = r_b[W-1] ? w_b_neg[W-1:0] : w_b_ext[W-1:0];
    assign w_p_mag  = r_p[W] ? w_p_neg[W-1:0] : r_p[W-1:0];
    assign w_q_mag  = r_q[W] ? w_q_neg[W-1:0] : r_q[W-1:0];
    assign w_rem_ext = {1'b0, w_div_rem};
    assign w_quo64   = RES_W'(w_div_quo);
    assign w_quo_pos = w_quo64;
    assign w_quo_neg = -w_quo_pos;

    // multiplier operand selection per step
    always_comb begin
        w_mx = r_a;
        w_my = r_d;
        case (r_kind)
            KIND_ADD, KIND_SUB: begin
                case (r_step)
                    2'd0:    begin w_mx = r_a; w_my = r_d; end
                    2'd1:    begin w_mx = r_c; w_my = r_b; end
                    default: begin w_mx = r_b; w_my = r_d; end
                endcase
            end
            KIND_MUL: begin
                if (r_step == 2'd0) begin
                    w_mx = r_a; w_my = r_c;
                end else begin
                    w_mx = r_b; w_my = r_d;
                end
            end
            KIND_DIV: begin
                if (r_step == 2'd0) begin
                    w_mx = r_a; w_my = r_d;
                end else begin
                    w_mx = r_b; w_my = r_c;
                end
            end
            default: begin
                w_mx = r_a; w_my = r_d;
            end
        endcase
    end

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= w_mx * w_my;
        end
    end

    assign w_prod64 = RES_W'(r_prod);
    assign w_sum    = (r_kind == KIND_SUB) ? (r_num - w_prod64) : (r_num + w_prod64);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_step      = r_step;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_num       = r_num;
        n_den       = r_den;
        n_zd        = r_zd;
        n_ov        = r_ov;
        n_p         = r_p;
        n_q         = r_q;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_zd    = r_out_zd;
        n_out_ov    = r_out_ov;
        w_div_start = 1'b0;
        w_div_dvd   = w_p_mag;
        w_div_dvs   = w_q_mag;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_kind = i_in.kind;
                    n_a    = i_in.first_num[W-1:0];
                    n_b    = i_in.first_den[W-1:0];
                    n_c    = i_in.second_num[W-1:0];
                    n_d    = i_in.second_den[W-1:0];
                    n_step = 2'd0;
                    n_zd   = 1'b0;
                    n_ov   = 1'b0;
                    n_num  = '0;
                    n_den  = RES_W'(1);
                    n_p    = (W+1)'(n_a);
                    n_q    = (W+1)'(n_b);
                    case (i_in.kind)
                        KIND_ADD, KIND_SUB: begin
                            if (n_b == n_d) begin
                                // equal denominators: no products needed
                                n_num = (i_in.kind == KIND_SUB)
                                      ? (RES_W'(n_a) - RES_W'(n_c))
                                      : (RES_W'(n_a) + RES_W'(n_c));
                                n_den   = RES_W'(n_b);
                                n_state = ST_OUT;
                            end else begin
                                n_state = ST_MUL;
                            end
                        end
                        KIND_MUL: n_state = ST_MUL;
                        KIND_DIV: begin
                            n_zd    = (n_c == '0);
                            n_state = ST_MUL;
                        end
                        KIND_SIMP: n_state = ST_GCD;
                        default:   n_state = ST_OUT;
                    endcase
                end
            end

            // one product per cycle, consumed in the next cycle
            ST_MUL: begin
                n_step = r_step + 2'd1;
                if (r_kind == KIND_ADD || r_kind == KIND_SUB) begin
                    case (r_step)
                        2'd0: ;
                        2'd1: n_num = w_prod64;
                        2'd2: begin
                            n_num = w_sum;
                            if (r_kind == KIND_SUB) begin
                                n_ov = (r_num[RES_W-1] ^ w_prod64[RES_W-1])
                                     & (r_num[RES_W-1] ^ w_sum[RES_W-1]);
                            end else begin
                                n_ov = (r_num[RES_W-1] ^ w_sum[RES_W-1])
                                     & (w_prod64[RES_W-1] ^ w_sum[RES_W-1]);
                            end
                        end
                        default: begin
                            n_den   = w_prod64;
                            n_state = ST_OUT;
                        end
                    endcase
                end else begin
                    case (r_step)
                        2'd0: ;
                        2'd1: n_num = w_prod64;
                        default: begin
                            n_den   = w_prod64;
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end

            // euclid loop on truncating remainder
            ST_GCD: begin
                if (r_q == '0) begin
                    if (r_p == '0) begin
                        n_zd    = 1'b1;
                        n_num   = '0;
                        n_den   = '0;
                        n_state = ST_OUT;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_dvd   = w_a_mag;
                        w_div_dvs   = w_p_mag;
                        n_state     = ST_QA_WAIT;
                    end
                end else begin
                    w_div_start = 1'b1;
                    w_div_dvd   = w_p_mag;
                    w_div_dvs   = w_q_mag;
                    n_state     = ST_GCD_WAIT;
                end
            end

            ST_GCD_WAIT: begin
                if (w_div_done) begin
                    n_p     = r_q;
                    n_q     = r_p[W] ? -w_rem_ext : w_rem_ext;
                    n_state = ST_GCD;
                end
            end

            // quotient of the numerator by the gcd
            ST_QA_WAIT: begin
                if (w_div_done) begin
                    n_num   = (r_a[W-1] ^ r_p[W]) ? w_quo_neg : w_quo_pos;
                    n_state = ST_QB;
                end
            end

            ST_QB: begin
                w_div_start = 1'b1;
                w_div_dvd   = w_b_mag;
                w_div_dvs   = w_p_mag;
                n_state     = ST_QB_WAIT;
            end

            ST_QB_WAIT: begin
                if (w_div_done) begin
                    n_den   = (r_b[W-1] ^ r_p[W]) ? w_quo_neg : w_quo_pos;
                    n_state = ST_OUT;
                end
            end

            // hand the result to the output register
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_num;
                    n_out_den   = r_den;
                    n_out_zd    = r_zd;
                    n_out_ov    = r_ov;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_step    <= n_step;
        r_a       <= n_a;
        r_b       <= n_b;
        r_c       <= n_c;
        r_d       <= n_d;
        r_num     <= n_num;
        r_den     <= n_den;
        r_zd      <= n_zd;
        r_ov      <= n_ov;
        r_p       <= n_p;
        r_q       <= n_q;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        r_out_zd  <= n_out_zd;
        r_out_ov  <= n_out_ov;
    end

    // ports
    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_num   = r_out_num;
    assign o_out.result_den   = r_out_den;
    assign o_out.zero_divisor = r_out_zd;
    assign o_out.overflowed   = r_out_ov;

    // checks
    a_gcd_step_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD_WAIT && w_div_done) |=> (r_state == ST_GCD))
        else $error("euclid step did not return to the loop head");

    a_zd_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_zd) |-> (r_kind == KIND_DIV || r_kind == KIND_SIMP))
        else $error("zero divisor flag on an operation that cannot divide by zero");

    a_ov_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_ov) |-> (r_kind == KIND_ADD || r_kind == KIND_SUB))
        else $error("overflow flag on an operation that cannot overflow");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !o_out.ready) |=> (r_state == ST_OUT))
        else $error("result left the sequencer while the output was still full");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rational arithmetic unit. A table of hand-picked
// items comes first: extremes, each operation, zero divisors, zero gcd and the
// spare kind codes. Random items follow in three idling phases. Every result
// item is matched in order to a typed row's answer or the in-bench fraction model.
// ----------------------------------------------------------------------------
module testbench;
    import rau_pkg::*;

    // run sizes and timing
    localparam int    RANDOM_ITEMS  = 1800;
    localparam int    STALL_CYCLES  = 400;
    localparam int    SETTLE_CYCLES = 2000;
    localparam longint RUN_LIMIT    = 64'd125_000_000;

    // spare kind codes, expected to give 0/1 with no flags
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    localparam logic signed [FIELD_W-1:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] MAX32 = 32'sh7fff_ffff;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [FIELD_W-1:0] first_num;
        logic signed [FIELD_W-1:0] first_den;
        logic signed [FIELD_W-1:0] second_num;
        logic signed [FIELD_W-1:0] second_den;
    } t_operands;

    typedef struct packed {
        logic signed [RES_W-1:0] num;
        logic signed [RES_W-1:0] den;
        logic                    zero_div;
        logic                    ovf;
    } t_fraction;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        t_operands op;
        logic      typed;
        t_fraction want;
    } t_probe;

    localparam int NUM_PROBES = 25;

    localparam t_probe PROBE_TABLE [NUM_PROBES] = '{
        '{'{KIND_ADD,  1, 2, 1, 2},            1'b1, '{2, 2, 1'b0, 1'b0}},
        '{'{KIND_SUB,  3, 4, 1, 4},            1'b1, '{2, 4, 1'b0, 1'b0}},
        '{'{KIND_ADD,  1, 2, 1, 3},            1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_SUB,  1, 2, 1, 3},            1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_MUL,  2, 3, 5, 7},            1'b1, '{10, 21, 1'b0, 1'b0}},
        '{'{KIND_DIV,  2, 3, 5, 7},            1'b1, '{14, 15, 1'b0, 1'b0}},
        '{'{KIND_DIV,  1, 2, 0, 5},            1'b1, '{5, 0, 1'b1, 1'b0}},
        '{'{KIND_SIMP, 6, 4, 0, 0},            1'b1, '{3, 2, 1'b0, 1'b0}},
        '{'{KIND_SIMP, 0, 0, 7, 9},            1'b1, '{0, 0, 1'b1, 1'b0}},
        '{'{KIND_SIMP, 0, 5, 0, 0},            1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{KIND_SIMP, -6, 4, 0, 0},           1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_SIMP, 5, 0, 0, 0},            1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_SIMP, MIN32, MIN32, 0, 0},    1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_SIMP, MIN32, -1, 0, 0},       1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_ADD,  MIN32, MAX32, MIN32, MIN32}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_SUB,  MIN32, MIN32, MIN32, MAX32}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_SUB,  MAX32, MIN32, MIN32, MAX32}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_MUL,  MIN32, MIN32, MIN32, MIN32}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_DIV,  MAX32, -1, MIN32, MAX32},    1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{KIND_ADD,  1, 0, 1, 0},            1'b1, '{2, 0, 1'b0, 1'b0}},
        '{'{KIND_SUB,  -1, -1, -1, -1},        1'b1, '{0, -1, 1'b0, 1'b0}},
        '{'{KIND_SPARE_A, MAX32, MIN32, -1, 0}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{KIND_SPARE_B, -1, -1, -1, -1},     1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{KIND_SPARE_C, MIN32, MAX32, 0, 1}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{KIND_SIMP, MAX32, MIN32, 0, 0},    1'b0, '{0, 0, 1'b0, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    t_fraction pending_fractions [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 22;
    int        recv_idle_pct  = 67;
    int        hold_requests  = 0;

    rational_arithmetic_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // fraction maths of one item, wrapping at 64 bits
    function automatic t_fraction rational_result(input t_operands op);
        longint    a, b, c, d, p, q, t;
        logic [RES_W-1:0] x, y, s;
        t_fraction r;
        a = longint'($signed(op.first_num));
        b = longint'($signed(op.first_den));
        c = longint'($signed(op.second_num));
        d = longint'($signed(op.second_den));
        r = '{0, 1, 1'b0, 1'b0};
        case (op.kind)
            KIND_ADD, KIND_SUB: begin
                if (b == d) begin
                    r.num = (op.kind == KIND_ADD) ? a + c : a - c;
                    r.den = b;
                end else begin
                    x = a * d;
                    y = c * b;
                    if (op.kind == KIND_ADD) begin
                        s     = x + y;
                        r.ovf = (x[RES_W-1] ^ s[RES_W-1]) & (y[RES_W-1] ^ s[RES_W-1]);
                    end else begin
                        s     = x - y;
                        r.ovf = (x[RES_W-1] ^ y[RES_W-1]) & (x[RES_W-1] ^ s[RES_W-1]);
                    end
                    r.num = s;
                    r.den = b * d;
                end
            end
            KIND_MUL: begin
                r.num = a * c;
                r.den = b * d;
            end
            KIND_DIV: begin
                r.num      = a * d;
                r.den      = b * c;
                r.zero_div = (c == 0);
            end
            KIND_SIMP: begin
                // euclid with truncating remainder, so the gcd may be negative
                p = a;
                q = b;
                while (q != 0) begin
                    t = q;
                    q = p % q;
                    p = t;
                end
                if (p == 0) begin
                    r = '{0, 0, 1'b1, 1'b0};
                end else begin
                    r.num = a / p;
                    r.den = b / p;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly full-range values, some small ones and some extremes
    function automatic logic signed [FIELD_W-1:0] random_field();
        logic signed [FIELD_W-1:0] v;
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            v = $urandom;
        end else if (pick < 80) begin
            v = 32'(int'($urandom_range(40)) - 20);
        end else begin
            case ($urandom_range(4))
                0:       v = 0;
                1:       v = 1;
                2:       v = -1;
                3:       v = MIN32;
                default: v = MAX32;
            endcase
        end
        return v;
    endfunction

    function automatic t_operands random_operands();
        t_operands op;
        int pick;
        int factor;
        pick          = $urandom_range(99);
        op.first_num  = random_field();
        op.first_den  = random_field();
        op.second_num = random_field();
        op.second_den = random_field();
        if (pick < 20)      op.kind = KIND_ADD;
        else if (pick < 40) op.kind = KIND_SUB;
        else if (pick < 55) op.kind = KIND_MUL;
        else if (pick < 70) op.kind = KIND_DIV;
        else if (pick < 95) op.kind = KIND_SIMP;
        else                op.kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        // equal denominators take the short add/subtract path
        if ((op.kind == KIND_ADD || op.kind == KIND_SUB) && $urandom_range(99) < 30)
            op.second_den = op.first_den;
        if (op.kind == KIND_DIV && $urandom_range(99) < 10)
            op.second_num = 0;
        // shared factor so that simplify has something to cancel
        if (op.kind == KIND_SIMP && $urandom_range(99) < 30) begin
            factor        = int'($urandom_range(1, 2000));
            op.first_num  = 32'(factor * (int'($urandom_range(2000000)) - 1000000));
            op.first_den  = 32'(factor * (int'($urandom_range(2000000)) - 1000000));
        end
        return op;
    endfunction

    // offer one item, with random idle cycles ahead of it
    task automatic offer_item(input t_operands op, input logic typed, input t_fraction want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= op.kind;
        in_ch.first_num  <= op.first_num;
        in_ch.first_den  <= op.first_den;
        in_ch.second_num <= op.second_num;
        in_ch.second_den <= op.second_den;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_fractions.push_back(typed ? want : rational_result(op));
    endtask

    // stop offering until every expected result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_fractions.size() != 0);
    endtask

    // result receiver: random stalls plus an occasional long hold-off
    initial begin
        int hold_left;
        int hold_served;
        hold_left    = 0;
        hold_served  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_fraction want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_fractions.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatch_count++;
            end else begin
                want = pending_fractions.pop_front();
                if (out_ch.result_num !== want.num) begin
                    $error("result_num: expected %0d, got %0d", want.num, out_ch.result_num);
                    mismatch_count++;
                end
                if (out_ch.result_den !== want.den) begin
                    $error("result_den: expected %0d, got %0d", want.den, out_ch.result_den);
                    mismatch_count++;
                end
                if (out_ch.zero_divisor !== want.zero_div) begin
                    $error("zero_divisor: expected %0b, got %0b",
                           want.zero_div, out_ch.zero_divisor);
                    mismatch_count++;
                end
                if (out_ch.overflowed !== want.ovf) begin
                    $error("overflowed: expected %0b, got %0b", want.ovf, out_ch.overflowed);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int n;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = '0;
        in_ch.first_num  = '0;
        in_ch.first_den  = '0;
        in_ch.second_num = '0;
        in_ch.second_den = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (n = 0; n < NUM_PROBES; n++)
            offer_item(PROBE_TABLE[n].op, PROBE_TABLE[n].typed, PROBE_TABLE[n].want);
        drain_results();

        // random items: sender idles less, then receiver idles less, then neither
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 67;
                recv_idle_pct = 22;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver hold-off while items keep being offered
            if (n == 100 || n == 1500)
                hold_requests++;
            offer_item(random_operands(), 1'b0, '0);
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_fractions.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
